// ===== rtl/core/cbse_pkg.sv =====
// ----------------------------------------------------------------------------
// cbse_pkg: shared constants and types of the crystal ball shape evaluator
// Fixed-point formats, series constants, register indexes and the flag bundle
// that travels with each item through the pipeline.
// ----------------------------------------------------------------------------
package cbse_pkg;

  localparam int SAMPLE_WIDTH_DEF     = 32;
  localparam int RESULT_FRAC_BITS_DEF = 31;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_POSITION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_CUT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_POWER    = 2'd3;

  localparam int SIG_W = 32;
  localparam int A_W   = 24;
  localparam int N_W   = 24;

  localparam int U_W       = 62;
  localparam int W_W       = 54;
  localparam int LOG_IN_W  = 63;
  localparam int LOG_E_W   = 6;
  localparam int LOG_OUT_W = LOG_E_W + 32;
  localparam int Y_W       = 48;
  localparam int K_W       = Y_W - 32;
  localparam int G_W       = 34;
  localparam int T_W       = 33;

  localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam int          EXP_TERMS = 12;

  typedef struct packed {
    logic zero_out;
    logic in_tail;
    logic status;
  } cbse_flags_t;

endpackage

// ===== rtl/core/crystal_ball_shape_eval_unit.sv =====
// ----------------------------------------------------------------------------
// crystal_ball_shape_eval_unit: unnormalized crystal ball shape evaluator
// Gaussian core / power-law tail of one sample per transaction, fixed point.
//
//   channel  dir  handshake           content
//   s_*      in   s_tvalid/s_tready   sample_value (Q16.16)
//   m_*      out  m_tvalid/m_tready   shape_value (Q1.31), in_tail, status
//   cfg_*    in   cfg_we              register index and write data
//
// One transaction per cycle sustained while the skid register is empty; the
// path runs through the bit-per-stage divider (DIV_W = SAMPLE_WIDTH + 31 for
// widths of 23 and up, 63 at the default), the 32 squaring stages of the log2
// unit and the two-stage-per-term exp series.
// Reset clears all valid bits and loads the register defaults.
// The pipeline holds only when both the output register and skid are full.
// ----------------------------------------------------------------------------
module crystal_ball_shape_eval_unit import cbse_pkg::*; #(
  parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // sample_value
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // shape_value
  output logic [1:0]            m_tuser,   // in_tail, status
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int XW    = (SW > 32) ? SW : 32;
  localparam int DIV_W = (SW + 31 > W_W) ? SW + 31 : W_W;
  localparam int QX_W  = (DIV_W > 63) ? DIV_W : 63;
  localparam int L_SIDE_W = Y_W + $bits(cbse_flags_t);

  logic [31:0]    peak_position;
  logic [SIG_W-1:0] core_width;
  logic [A_W-1:0] tail_cut;
  logic [N_W-1:0] tail_power;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_position <= '0;
      core_width    <= SIG_W'(65536);
      tail_cut      <= A_W'(65536);
      tail_power    <= N_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PEAK_POSITION: peak_position <= cfg_data;
        REG_CORE_WIDTH:    core_width    <= cfg_data;
        REG_TAIL_CUT:      tail_cut      <= cfg_data[A_W-1:0];
        REG_TAIL_POWER:    tail_power    <= cfg_data[N_W-1:0];
        default:           ;
      endcase
    end
  end

  logic           en;
  logic           skid_valid;
  logic [A_W-1:0] a_mag;
  logic           sig0;

  assign en       = !skid_valid;
  assign s_tready = en;
  assign a_mag    = tail_cut[A_W-1] ? (~tail_cut + 1'b1) : tail_cut;
  assign sig0     = (core_width == '0);

  // input stage: |m - m0|
  logic [XW-1:0] m_ext, m0_ext;
  logic [SW:0]   diff, ud;
  logic          s0_valid;
  logic [SW:0]   s0_ud;
  logic          s0_dneg;

  assign m_ext  = XW'(s_tdata);
  assign m0_ext = XW'(peak_position);
  assign diff   = {m_ext[SW-1], m_ext[SW-1:0]} - {m0_ext[SW-1], m0_ext[SW-1:0]};
  assign ud     = diff[SW] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_tvalid;
    end
    if (en) begin
      s0_ud   <= ud;
      s0_dneg <= diff[SW];
    end
  end

  // quotients: |d| / sigma in Q.30 and n / |alpha| in Q.30
  logic             dv_valid;
  logic [DIV_W-1:0] dv_qa, dv_qb;
  logic             dv_dneg;

  cbse_div #(
    .NUM_W  (DIV_W),
    .DEN_W  (SIG_W),
    .SIDE_W (1)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_valid),
    .num_a     (DIV_W'(s0_ud) << 30),
    .num_b     (DIV_W'(tail_power) << 30),
    .den_a     (core_width),
    .den_b     (SIG_W'(a_mag)),
    .side_in   (s0_dneg),
    .out_valid (dv_valid),
    .quo_a     (dv_qa),
    .quo_b     (dv_qb),
    .side_out  (dv_dneg)
  );

  // branch select
  logic [QX_W-1:0] q_ext;
  logic [U_W-1:0]  u, s;
  logic [W_W-1:0]  w;
  logic [37:0]     a14;
  logic            core, neg;
  logic [30:0]     sq_op;
  cbse_flags_t     p1_flags_next;

  assign q_ext = QX_W'(dv_qa);
  assign u     = (q_ext >= (QX_W'(1) << 62)) ? {U_W{1'b1}} : q_ext[U_W-1:0];
  assign w     = dv_qb[W_W-1:0];
  assign a14   = {a_mag, 14'd0};
  assign neg   = dv_dneg ^ tail_cut[A_W-1];
  assign core  = neg ? (u < U_W'(a14)) : ((u != '0) || (a_mag != '0));
  assign s     = u - U_W'(a14);
  assign sq_op = core ? u[32:2] : 31'(a_mag);

  always_comb begin
    p1_flags_next.zero_out = sig0 || (core ? (u[U_W-1:33] != '0) : (a_mag == '0));
    p1_flags_next.in_tail  = !sig0 && !core;
    p1_flags_next.status   = sig0 || (!core && (a_mag == '0));
  end

  logic                p1_valid, p1_core;
  logic [61:0]         p1_sq;
  logic [LOG_IN_W-1:0] p1_sw;
  logic [W_W-1:0]      p1_w;
  cbse_flags_t         p1_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= dv_valid;
    end
    if (en) begin
      p1_core  <= core;
      p1_sq    <= 62'(sq_op) * 62'(sq_op);
      p1_sw    <= LOG_IN_W'(s) + LOG_IN_W'(w);
      p1_w     <= w;
      p1_flags <= p1_flags_next;
    end
  end

  // square times log2(e)
  logic [45:0] v;
  assign v = p1_core ? 46'(p1_sq >> 25) : 46'(p1_sq >> 1);

  logic                p2_valid;
  logic [64:0]         p2_pl;
  logic [46:0]         p2_ph;
  logic [LOG_IN_W-1:0] p2_sw;
  logic [W_W-1:0]      p2_w;
  cbse_flags_t         p2_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
    if (en) begin
      p2_pl    <= 65'(v[31:0]) * 65'(LOG2E_Q32);
      p2_ph    <= 47'(v[45:32]) * 47'(LOG2E_Q32);
      p2_sw    <= p1_sw;
      p2_w     <= p1_w;
      p2_flags <= p1_flags;
    end
  end

  logic                p3_valid;
  logic [Y_W-1:0]      p3_y0;
  logic [LOG_IN_W-1:0] p3_sw;
  logic [W_W-1:0]      p3_w;
  cbse_flags_t         p3_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en) begin
      p3_valid <= p2_valid;
    end
    if (en) begin
      p3_y0    <= Y_W'(p2_ph) + Y_W'(p2_pl >> 32);
      p3_sw    <= p2_sw;
      p3_w     <= p2_w;
      p3_flags <= p2_flags;
    end
  end

  // tail logarithms
  logic                 lg_valid;
  logic [LOG_OUT_W-1:0] lg_t, lg_w;
  logic [L_SIDE_W-1:0]  lg_side;
  logic [Y_W-1:0]       lg_y0;
  cbse_flags_t          lg_flags;

  cbse_log2 #(
    .SIDE_W (L_SIDE_W)
  ) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p3_valid),
    .val_a     (p3_sw),
    .val_b     (LOG_IN_W'(p3_w)),
    .side_in   ({p3_y0, p3_flags}),
    .out_valid (lg_valid),
    .log_a     (lg_t),
    .log_b     (lg_w),
    .side_out  (lg_side)
  );

  assign {lg_y0, lg_flags} = lg_side;

  logic [LOG_OUT_W-1:0] dl;
  assign dl = (lg_t > lg_w) ? lg_t - lg_w : '0;

  logic           q1_valid;
  logic [55:0]    q1_plo;
  logic [29:0]    q1_phi;
  logic [Y_W-1:0] q1_y0;
  cbse_flags_t    q1_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid <= 1'b0;
    end else if (en) begin
      q1_valid <= lg_valid;
    end
    if (en) begin
      q1_plo   <= 56'(dl[31:0]) * 56'(tail_power);
      q1_phi   <= 30'(dl[LOG_OUT_W-1:32]) * 30'(tail_power);
      q1_y0    <= lg_y0;
      q1_flags <= lg_flags;
    end
  end

  logic [61:0] nd;
  logic        add_tail;
  assign nd       = (62'(q1_phi) << 32) + 62'(q1_plo);
  assign add_tail = q1_flags.in_tail && !q1_flags.zero_out && (tail_power != '0);

  logic           q2_valid;
  logic [Y_W-1:0] q2_y;
  cbse_flags_t    q2_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      q2_valid <= 1'b0;
    end else if (en) begin
      q2_valid <= q1_valid;
    end
    if (en) begin
      q2_y     <= q1_y0 + (add_tail ? Y_W'(nd >> 16) : '0);
      q2_flags <= q1_flags;
    end
  end

  // 2^-y
  logic           ex_valid;
  logic [G_W-1:0] ex_g;
  logic [K_W-1:0] ex_k;
  cbse_flags_t    ex_flags;

  cbse_exp2 #(
    .SIDE_W ($bits(cbse_flags_t))
  ) u_exp2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q2_valid),
    .y         (q2_y),
    .side_in   (q2_flags),
    .out_valid (ex_valid),
    .g_out     (ex_g),
    .k_out     (ex_k),
    .side_out  (ex_flags)
  );

  // round to Q1.RESULT_FRAC_BITS and clamp
  logic [63:0] g64, r;
  int          sh;
  logic [33:0] res;

  always_comb begin
    g64 = 64'(ex_g);
    sh  = 32 + int'(ex_k) - RESULT_FRAC_BITS;
    r   = '0;
    if (ex_k < K_W'(96)) begin
      if (sh >= 64) r = '0;
      else if (sh > 0) r = (g64 + (64'd1 << (sh - 1))) >> sh;
      else r = g64 << (-sh);
    end
    if (r > (64'd1 << RESULT_FRAC_BITS)) r = 64'd1 << RESULT_FRAC_BITS;
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    res = {ex_flags.status, ex_flags.in_tail, ex_flags.zero_out ? 32'd0 : r[31:0]};
  end

  // output register with skid
  logic        out_valid;
  logic [33:0] out_word, skid_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en) begin
      if (out_valid && !m_tready) skid_valid <= ex_valid;
      else out_valid <= ex_valid;
    end else if (m_tready) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end
    if (en) begin
      if (out_valid && !m_tready) skid_word <= res;
      else out_word <= res;
    end else if (m_tready) begin
      out_word <= skid_word;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_word[31:0];
  assign m_tuser  = out_word[33:32];

endmodule

// ===== rtl/core/cbse_div.sv =====
// ----------------------------------------------------------------------------
// cbse_div: two-lane pipelined restoring divider
// One quotient bit per stage per lane; the user must hold divisors stable while
// items are in flight (not enforced). A sideband word rides along with each item.
// ----------------------------------------------------------------------------
module cbse_div #(
  parameter int NUM_W  = 63,
  parameter int DEN_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num_a,
  input  logic [NUM_W-1:0]  num_b,
  input  logic [DEN_W-1:0]  den_a,
  input  logic [DEN_W-1:0]  den_b,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo_a,
  output logic [NUM_W-1:0]  quo_b,
  output logic [SIDE_W-1:0] side_out
);

  function automatic logic [DEN_W+NUM_W-1:0] div_step(
    logic [DEN_W-1:0] rem, logic [NUM_W-1:0] nq, logic [DEN_W-1:0] den);
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    trial = {rem, nq[NUM_W-1]};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {diff[DEN_W-1:0], nq[NUM_W-2:0], 1'b1};
    end
    return {trial[DEN_W-1:0], nq[NUM_W-2:0], 1'b0};
  endfunction

  logic [DEN_W-1:0]  rem [2][NUM_W];
  logic [NUM_W-1:0]  nq  [2][NUM_W+1];
  logic [DEN_W-1:0]  den [2];
  logic [SIDE_W-1:0] side [NUM_W+1];
  logic [NUM_W:0]    vld;

  assign den[0]   = den_a;
  assign den[1]   = den_b;
  assign rem[0][0] = '0;
  assign rem[1][0] = '0;
  assign nq[0][0]  = num_a;
  assign nq[1][0]  = num_b;
  assign side[0]   = side_in;
  assign vld[0]    = in_valid;

  for (genvar j = 0; j < NUM_W; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
      if (en) begin
        side[j+1] <= side[j];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DEN_W+NUM_W-1:0] step;
      assign step = div_step(rem[l][j], nq[l][j], den[l]);

      always_ff @(posedge clk) begin
        if (en) begin
          nq[l][j+1] <= step[NUM_W-1:0];
        end
      end

      if (j < NUM_W - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem[l][j+1] <= step[DEN_W+NUM_W-1:NUM_W];
          end
        end
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quo_a     = nq[0][NUM_W];
  assign quo_b     = nq[1][NUM_W];
  assign side_out  = side[NUM_W];

endmodule

// ===== rtl/core/cbse_log2.sv =====
// ----------------------------------------------------------------------------
// cbse_log2: two-lane pipelined base-2 logarithm
// Normalizes the operand in one stage, then yields one fraction bit per
// stage by repeated squaring of the mantissa. Result is Q.32.
// ----------------------------------------------------------------------------
module cbse_log2 import cbse_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [LOG_IN_W-1:0]  val_a,
  input  logic [LOG_IN_W-1:0]  val_b,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 out_valid,
  output logic [LOG_OUT_W-1:0] log_a,
  output logic [LOG_OUT_W-1:0] log_b,
  output logic [SIDE_W-1:0]    side_out
);

  function automatic logic [LOG_E_W+31:0] lg_norm(logic [LOG_IN_W-1:0] v);
    logic [LOG_E_W-1:0] e;
    logic [31:0]        m;
    e = '0;
    for (int b = 0; b < LOG_IN_W; b++) begin
      if (v[b]) e = LOG_E_W'(b);
    end
    if (e >= LOG_E_W'(31)) m = 32'(v >> (e - LOG_E_W'(31)));
    else m = 32'(v << (LOG_E_W'(31) - e));
    return {e, m};
  endfunction

  function automatic logic [32:0] lg_sq(logic [31:0] m);
    logic [63:0] p;
    logic [32:0] r;
    p = 64'(m) * 64'(m);
    r = p[63:31];
    if (r[32]) return {1'b1, r[32:1]};
    return {1'b0, r[31:0]};
  endfunction

  logic [LOG_IN_W-1:0] val [2];
  logic [LOG_E_W-1:0]  ex   [2][33];
  logic [31:0]         mant [2][32];
  logic [31:0]         frac [2][33];
  logic [SIDE_W-1:0]   side [33];
  logic [32:0]         vld;

  assign val[0] = val_a;
  assign val[1] = val_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      side[0] <= side_in;
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
      if (en) begin
        side[j+1] <= side[j];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [LOG_E_W+31:0] nrm;
    assign nrm       = lg_norm(val[l]);
    assign frac[l][0] = '0;

    always_ff @(posedge clk) begin
      if (en) begin
        ex[l][0]   <= nrm[LOG_E_W+31:32];
        mant[l][0] <= nrm[31:0];
      end
    end

    for (genvar j = 0; j < 32; j++) begin : g_sq
      logic [32:0] sq;
      assign sq = lg_sq(mant[l][j]);

      always_ff @(posedge clk) begin
        if (en) begin
          ex[l][j+1]   <= ex[l][j];
          frac[l][j+1] <= {frac[l][j][30:0], sq[32]};
        end
      end

      if (j < 31) begin : g_m
        always_ff @(posedge clk) begin
          if (en) begin
            mant[l][j+1] <= sq[31:0];
          end
        end
      end
    end
  end

  assign out_valid = vld[32];
  assign log_a     = {ex[0][32], frac[0][32]};
  assign log_b     = {ex[1][32], frac[1][32]};
  assign side_out  = side[32];

endmodule

// ===== rtl/core/cbse_exp2.sv =====
// ----------------------------------------------------------------------------
// cbse_exp2: pipelined 2^-y series unit
// Splits y into integer part k and fraction, maps the fraction to e^-z and
// sums a 12-term Taylor series, two stages per term (product, reciprocal).
// ----------------------------------------------------------------------------
module cbse_exp2 import cbse_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [Y_W-1:0]    y,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [G_W-1:0]    g_out,
  output logic [K_W-1:0]    k_out,
  output logic [SIDE_W-1:0] side_out
);

  logic [31:0]       zb [EXP_TERMS];
  logic [T_W-1:0]    tb [EXP_TERMS];
  logic [G_W-1:0]    gb [EXP_TERMS+1];
  logic [K_W-1:0]    kb [EXP_TERMS+1];
  logic [SIDE_W-1:0] sb [EXP_TERMS+1];
  logic [EXP_TERMS:0] vb;

  logic [63:0] zprod;
  assign zprod = 64'(y[31:0]) * 64'(LN2_Q32);

  assign gb[0] = G_W'(64'd1 << 32);
  assign tb[0] = T_W'(64'd1 << 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb[0] <= 1'b0;
    end else if (en) begin
      vb[0] <= in_valid;
    end
    if (en) begin
      zb[0] <= zprod[63:32];
      kb[0] <= y[Y_W-1:32];
      sb[0] <= side_in;
    end
  end

  for (genvar i = 1; i <= EXP_TERMS; i++) begin : g_term
    localparam int          TI = i;
    localparam int          RL = $clog2(TI);
    localparam logic [32:0] RM = 33'(((64'd1 << (32 + RL)) + 64'(TI) - 64'd1) / 64'(TI));

    logic              a_vld;
    logic [31:0]       a_p;
    logic [31:0]       a_z;
    logic [G_W-1:0]    a_g;
    logic [K_W-1:0]    a_k;
    logic [SIDE_W-1:0] a_s;
    logic [64:0]       tz;
    logic [64:0]       pr;
    logic [31:0]       q;

    assign tz = 65'(tb[i-1]) * 65'(zb[i-1]);
    assign pr = 65'(a_p) * 65'(RM);
    assign q  = 32'(pr >> (32 + RL));

    always_ff @(posedge clk) begin
      if (rst) begin
        a_vld <= 1'b0;
        vb[i] <= 1'b0;
      end else if (en) begin
        a_vld <= vb[i-1];
        vb[i] <= a_vld;
      end
      if (en) begin
        a_p   <= 32'(tz >> 32);
        a_z   <= zb[i-1];
        a_g   <= gb[i-1];
        a_k   <= kb[i-1];
        a_s   <= sb[i-1];
        gb[i] <= ((TI % 2) == 1) ? a_g - G_W'(q) : a_g + G_W'(q);
        kb[i] <= a_k;
        sb[i] <= a_s;
      end
    end

    if (i < EXP_TERMS) begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          zb[i] <= a_z;
          tb[i] <= T_W'(q);
        end
      end
    end
  end

  assign out_valid = vb[EXP_TERMS];
  assign g_out     = gb[EXP_TERMS];
  assign k_out     = kb[EXP_TERMS];
  assign side_out  = sb[EXP_TERMS];

endmodule
